/* hdl/lidar_beam_to_pixel_projection_unit_macros.svh */
// assertion macros for the lidar beam to pixel projection unit
// used by the top level only, empty under synthesis
`ifndef LIDAR_BEAM_TO_PIXEL_PROJECTION_UNIT_MACROS_SVH
`define LIDAR_BEAM_TO_PIXEL_PROJECTION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LBPP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lbpp check failed");
`define LBPP_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lbpp check failed");
`else
`define LBPP_ASSERT(lbl, cond)
`define LBPP_ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

/* hdl/lbpp_pkg.sv */
// shared constants, types and tables for the projection unit
// no dependencies
`default_nettype none
package lbpp_pkg;
  localparam int ANGLE_BITS  = 16;
  localparam int COEFF_BITS  = 18;
  localparam int INDEX_BITS  = 12;
  localparam int RANGE_BITS  = 16;
  localparam int PIX_BITS    = 12;
  localparam int DIM_BITS    = 13;
  localparam int CFG_BITS    = 3 * COEFF_BITS;
  localparam int CORDIC_ITERS = 16;
  localparam int CXY_W       = 33;
  localparam int CZ_W        = 34;
  localparam int CS_W        = 18;
  localparam int XY_W        = RANGE_BITS + 1 + CS_W;
  localparam int PROD_W      = COEFF_BITS + XY_W;
  localparam int ACC_W       = PROD_W + 3;
  localparam int QB          = PIX_BITS + 1;
  localparam logic [CXY_W-1:0] CORDIC_GAIN = CXY_W'(32'h26DD3B6A);
  localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(4096);

  // register indexes
  localparam logic [2:0] REG_ANGLE_START = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_IMG_WIDTH   = 3'd2;
  localparam logic [2:0] REG_IMG_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_PROJ_U      = 3'd4;
  localparam logic [2:0] REG_PROJ_V      = 3'd5;
  localparam logic [2:0] REG_PROJ_W      = 3'd6;

  typedef struct packed {
    logic                         valid;
    logic signed [CXY_W-1:0]      x;
    logic signed [CXY_W-1:0]      y;
    logic signed [CZ_W-1:0]       z;
    logic [1:0]                   quad;
    logic [RANGE_BITS-1:0]        range;
  } cordic_stage_t;

  typedef struct packed {
    logic                  valid;
    logic                  wnz;
    logic                  col_pos;
    logic                  row_pos;
    logic [ACC_W-1:0]      dvs;
    logic [ACC_W-1:0]      rem_c;
    logic [ACC_W-1:0]      rem_r;
    logic [QB-1:0]         q_c;
    logic [QB-1:0]         q_r;
  } div_stage_t;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic signed [CZ_W-1:0] atan_units(input logic [3:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      4'd0:  r = CZ_W'(536870912);
      4'd1:  r = CZ_W'(316933406);
      4'd2:  r = CZ_W'(167458907);
      4'd3:  r = CZ_W'(85004756);
      4'd4:  r = CZ_W'(42667331);
      4'd5:  r = CZ_W'(21354465);
      4'd6:  r = CZ_W'(10679838);
      4'd7:  r = CZ_W'(5340245);
      4'd8:  r = CZ_W'(2670163);
      4'd9:  r = CZ_W'(1335087);
      4'd10: r = CZ_W'(667544);
      4'd11: r = CZ_W'(333772);
      4'd12: r = CZ_W'(166886);
      4'd13: r = CZ_W'(83443);
      4'd14: r = CZ_W'(41722);
      default: r = CZ_W'(20861);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* hdl/lbpp_cordic_cell.sv */
// one rotation step of the pipelined cordic
// depends on lbpp_pkg
`default_nettype none
module lbpp_cordic_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic [3:0]             iter,
  input  wire lbpp_pkg::cordic_stage_t din,
  output lbpp_pkg::cordic_stage_t     dout
);
  logic signed [lbpp_pkg::CXY_W-1:0] dx;
  logic signed [lbpp_pkg::CXY_W-1:0] dy;
  logic signed [lbpp_pkg::CZ_W-1:0]  at;

  // shifted terms, floor by arithmetic shift
  assign dx = din.y >>> iter;
  assign dy = din.x >>> iter;
  assign at = lbpp_pkg::atan_units(iter);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.quad  <= din.quad;
      dout.range <= din.range;
      if (!din.z[lbpp_pkg::CZ_W-1]) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - at;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + at;
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/lbpp_div_cell.sv */
// one restoring division step for column and row lanes
// depends on lbpp_pkg
`default_nettype none
module lbpp_div_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic [3:0]          shamt,
  input  wire lbpp_pkg::div_stage_t din,
  output lbpp_pkg::div_stage_t     dout
);
  localparam int TW = lbpp_pkg::ACC_W + lbpp_pkg::QB;
  logic [TW-1:0] dsh;
  logic          take_c;
  logic          take_r;

  // compare both remainders with the shifted divisor
  assign dsh    = {{lbpp_pkg::QB{1'b0}}, din.dvs} << shamt;
  assign take_c = {{lbpp_pkg::QB{1'b0}}, din.rem_c} >= dsh;
  assign take_r = {{lbpp_pkg::QB{1'b0}}, din.rem_r} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.wnz     <= din.wnz;
      dout.col_pos <= din.col_pos;
      dout.row_pos <= din.row_pos;
      dout.dvs     <= din.dvs;
      dout.rem_c   <= take_c ? din.rem_c - dsh[lbpp_pkg::ACC_W-1:0] : din.rem_c;
      dout.rem_r   <= take_r ? din.rem_r - dsh[lbpp_pkg::ACC_W-1:0] : din.rem_r;
      dout.q_c     <= {din.q_c[lbpp_pkg::QB-2:0], take_c};
      dout.q_r     <= {din.q_r[lbpp_pkg::QB-2:0], take_r};
    end
  end
endmodule
`default_nettype wire

/* hdl/lidar_beam_to_pixel_projection_unit.sv */
// one item per cycle sustained while no result waits at the output
// the pipeline holds 16 cordic cells and 13 divider cells, each one stage
// the whole pipeline stalls only while a result waits at the output
// reset (rst, synchronous) empties the pipeline and loads the register defaults
// depends on lbpp_pkg, lbpp_cordic_cell, lbpp_div_cell and the macro header
`default_nettype none
`include "lidar_beam_to_pixel_projection_unit_macros.svh"
module lidar_beam_to_pixel_projection_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [lbpp_pkg::CFG_BITS-1:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // beam_index [11:0], range_mm [27:12]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // pixel_col [11:0], pixel_row [23:12]
  output logic             m_tuser    // in_frame
);
  localparam int CB = lbpp_pkg::COEFF_BITS;
  localparam int AB = lbpp_pkg::ANGLE_BITS;
  localparam int AW = lbpp_pkg::ACC_W;
  localparam int PW = lbpp_pkg::PROD_W;
  localparam int XW = lbpp_pkg::XY_W;
  localparam int SW = lbpp_pkg::CS_W;

  logic [15:0] angle_start;
  logic [15:0] angle_step;
  logic [lbpp_pkg::DIM_BITS-1:0] image_width;
  logic [lbpp_pkg::DIM_BITS-1:0] image_height;
  logic [lbpp_pkg::CFG_BITS-1:0] proj_u;
  logic [lbpp_pkg::CFG_BITS-1:0] proj_v;
  logic [lbpp_pkg::CFG_BITS-1:0] proj_w;
  logic en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start  <= '0;
      angle_step   <= '0;
      image_width  <= lbpp_pkg::DIM_BITS'(640);
      image_height <= lbpp_pkg::DIM_BITS'(480);
      proj_u       <= '0;
      proj_v       <= '0;
      proj_w       <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        lbpp_pkg::REG_ANGLE_START: angle_start  <= cfg_data[15:0];
        lbpp_pkg::REG_ANGLE_STEP:  angle_step   <= cfg_data[15:0];
        lbpp_pkg::REG_IMG_WIDTH:   image_width  <= cfg_data[lbpp_pkg::DIM_BITS-1:0];
        lbpp_pkg::REG_IMG_HEIGHT:  image_height <= cfg_data[lbpp_pkg::DIM_BITS-1:0];
        lbpp_pkg::REG_PROJ_U:      proj_u       <= cfg_data;
        lbpp_pkg::REG_PROJ_V:      proj_v       <= cfg_data;
        lbpp_pkg::REG_PROJ_W:      proj_w       <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: beam index times step
  logic v1;
  logic [lbpp_pkg::RANGE_BITS-1:0] r1;
  logic [AB-1:0] prod1;
  logic [lbpp_pkg::INDEX_BITS+15:0] idx_mul;
  assign idx_mul = s_tdata[lbpp_pkg::INDEX_BITS-1:0] * angle_step;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      r1    <= s_tdata[27:12];
      prod1 <= idx_mul[AB-1:0];
    end
  end

  // beam angle, quadrant and residual feed the first cordic cell
  lbpp_pkg::cordic_stage_t cd [0:lbpp_pkg::CORDIC_ITERS];
  logic [AB-1:0] ang;
  assign ang = AB'(angle_start) + prod1;
  always_comb begin
    cd[0].valid = v1;
    cd[0].x     = lbpp_pkg::CORDIC_GAIN;
    cd[0].y     = '0;
    cd[0].z     = lbpp_pkg::CZ_W'({ang[AB-3:0], {(32 - AB){1'b0}}});
    cd[0].quad  = ang[AB-1:AB-2];
    cd[0].range = r1;
  end

  genvar gi;
  generate
    for (gi = 0; gi < lbpp_pkg::CORDIC_ITERS; gi++) begin : g_cordic
      lbpp_cordic_cell u_cell (
        .clk(clk), .rst(rst), .en(en), .iter(4'(gi)),
        .din(cd[gi]), .dout(cd[gi+1])
      );
    end
  endgenerate

  // quadrant fold and cut to q16
  logic signed [lbpp_pkg::CXY_W-1:0] xs;
  logic signed [lbpp_pkg::CXY_W-1:0] ys;
  logic signed [SW-1:0] xq;
  logic signed [SW-1:0] yq;
  logic vc;
  logic signed [SW-1:0] cosv;
  logic signed [SW-1:0] sinv;
  logic [lbpp_pkg::RANGE_BITS-1:0] rc;
  assign xs = cd[lbpp_pkg::CORDIC_ITERS].x >>> 14;
  assign ys = cd[lbpp_pkg::CORDIC_ITERS].y >>> 14;
  assign xq = SW'(xs);
  assign yq = SW'(ys);

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= cd[lbpp_pkg::CORDIC_ITERS].valid;
    if (en) begin
      rc <= cd[lbpp_pkg::CORDIC_ITERS].range;
      case (cd[lbpp_pkg::CORDIC_ITERS].quad)
        2'd0: begin cosv <= xq;  sinv <= yq;  end
        2'd1: begin cosv <= -yq; sinv <= xq;  end
        2'd2: begin cosv <= -xq; sinv <= -yq; end
        default: begin cosv <= yq; sinv <= -xq; end
      endcase
    end
  end

  // planar point in q16 mm
  logic vm1;
  logic signed [XW-1:0] px;
  logic signed [XW-1:0] py;
  logic signed [lbpp_pkg::RANGE_BITS:0] rs;
  assign rs = {1'b0, rc};
  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (en) vm1 <= vc;
    if (en) begin
      px <= XW'(rs * cosv);
      py <= XW'(rs * sinv);
    end
  end

  // coefficient products, x and y terms of each row
  logic vm2;
  logic signed [PW-1:0] pu0, pu1, pv0, pv1, pw0, pw1;
  logic signed [CB-1:0] cu2, cv2, cw2;
  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (en) vm2 <= vm1;
    if (en) begin
      pu0 <= PW'($signed(proj_u[CB-1:0]) * px);
      pu1 <= PW'($signed(proj_u[2*CB-1:CB]) * py);
      pv0 <= PW'($signed(proj_v[CB-1:0]) * px);
      pv1 <= PW'($signed(proj_v[2*CB-1:CB]) * py);
      pw0 <= PW'($signed(proj_w[CB-1:0]) * px);
      pw1 <= PW'($signed(proj_w[2*CB-1:CB]) * py);
      cu2 <= $signed(proj_u[3*CB-1:2*CB]);
      cv2 <= $signed(proj_v[3*CB-1:2*CB]);
      cw2 <= $signed(proj_w[3*CB-1:2*CB]);
    end
  end

  // row sums
  logic vs;
  logic signed [AW-1:0] su, sv, sw;
  always_ff @(posedge clk) begin
    if (rst) vs <= 1'b0;
    else if (en) vs <= vm2;
    if (en) begin
      su <= AW'(pu0) + AW'(pu1) + (AW'(cu2) <<< 16);
      sv <= AW'(pv0) + AW'(pv1) + (AW'(cv2) <<< 16);
      sw <= AW'(pw0) + AW'(pw1) + (AW'(cw2) <<< 16);
    end
  end

  // magnitudes and quotient signs
  lbpp_pkg::div_stage_t dv [0:lbpp_pkg::QB];
  always_ff @(posedge clk) begin
    if (rst) dv[0].valid <= 1'b0;
    else if (en) dv[0].valid <= vs;
    if (en) begin
      dv[0].wnz     <= sw != '0;
      dv[0].col_pos <= su[AW-1] == sw[AW-1];
      dv[0].row_pos <= sv[AW-1] == sw[AW-1];
      dv[0].dvs     <= sw[AW-1] ? -sw : sw;
      dv[0].rem_c   <= su[AW-1] ? -su : su;
      dv[0].rem_r   <= sv[AW-1] ? -sv : sv;
      dv[0].q_c     <= '0;
      dv[0].q_r     <= '0;
    end
  end

  generate
    for (gi = 0; gi < lbpp_pkg::QB; gi++) begin : g_div
      lbpp_div_cell u_cell (
        .clk(clk), .rst(rst), .en(en), .shamt(4'(lbpp_pkg::QB - 1 - gi)),
        .din(dv[gi]), .dout(dv[gi+1])
      );
    end
  endgenerate

  // bounds check and output register
  lbpp_pkg::div_stage_t df;
  logic [lbpp_pkg::DIM_BITS-1:0] wlim;
  logic [lbpp_pkg::DIM_BITS-1:0] hlim;
  logic ok;
  assign df   = dv[lbpp_pkg::QB];
  assign wlim = (image_width  > lbpp_pkg::MAX_DIM) ? lbpp_pkg::MAX_DIM : image_width;
  assign hlim = (image_height > lbpp_pkg::MAX_DIM) ? lbpp_pkg::MAX_DIM : image_height;
  assign ok = df.wnz && df.col_pos && df.row_pos && (df.q_c != '0) && (df.q_r != '0)
              && (df.q_c < wlim) && (df.q_r < hlim);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= df.valid;
    if (en) begin
      m_tdata <= ok ? {df.q_r[lbpp_pkg::PIX_BITS-1:0], df.q_c[lbpp_pkg::PIX_BITS-1:0]}
                    : '0;
      m_tuser <= ok;
    end
  end

  // checks
  `LBPP_ASSERT_IMPLY(a_out_zero, m_tvalid && !m_tuser, m_tdata == 24'd0)
  `LBPP_ASSERT_IMPLY(a_in_nonzero, m_tvalid && m_tuser, (m_tdata[11:0] != 12'd0) && (m_tdata[23:12] != 12'd0))
  `LBPP_ASSERT_IMPLY(a_stall_cause, !s_tready, m_tvalid && !m_tready)
endmodule
`default_nettype wire

/* tb/lidar_beam_to_pixel_projection_unit_checker.sv */
// scoreboard for the lidar beam to pixel projection unit: predicts each pixel
// from the shadow registers and compares every output transfer; uses lbpp_pkg
`timescale 1ns / 100ps
module lidar_beam_to_pixel_projection_unit_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [lbpp_pkg::CFG_BITS-1:0] cfg_data,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [31:0]                   s_tdata,   // beam_index [11:0], range_mm [27:12]
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [23:0]                   m_tdata,   // pixel_col [11:0], pixel_row [23:12]
  input  wire logic                          m_tuser,   // in_frame
  output int                                 errors,
  output int                                 pending
);
  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic        in_frame;
  } pixel_t;

  localparam longint ATAN_TAB [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  localparam int EXP_DEPTH = 64;

  // shadow copy of the register file
  logic [15:0]                   sh_start, sh_step;
  logic [12:0]                   sh_width, sh_height;
  logic [lbpp_pkg::CFG_BITS-1:0] sh_pu, sh_pv, sh_pw;

  // expected pixels in transfer order
  pixel_t     exp_mem [EXP_DEPTH];
  logic [5:0] wr_ptr, rd_ptr;
  int         count;

  assign pending = count;

  // one row of the projection matrix applied to (x, y, 1)
  function automatic longint apply_row(logic [lbpp_pkg::CFG_BITS-1:0] r, longint x,
                                       longint y);
    longint c0, c1, c2;
    c0 = longint'($signed(r[17:0]));
    c1 = longint'($signed(r[35:18]));
    c2 = longint'($signed(r[53:36]));
    return c0 * x + c1 * y + c2 * 65536;
  endfunction

  function automatic pixel_t project_beam(logic [11:0] idx, logic [15:0] rng);
    logic [15:0] ang;
    logic [1:0]  quad;
    longint cx, cy, cz, dx, dy, cs, sn, x, y, u, v, w, col, row, wl, hl;
    pixel_t p;
    ang  = sh_start + idx * sh_step;
    quad = ang[15:14];
    cx = 64'h26DD3B6A;
    cy = 0;
    cz = longint'(ang[13:0]) <<< 16;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= ATAN_TAB[i];
      end else begin
        cx += dx; cy -= dy; cz += ATAN_TAB[i];
      end
    end
    cx = cx >>> 14;
    cy = cy >>> 14;
    case (quad)
      2'd0: begin cs = cx;  sn = cy;  end
      2'd1: begin cs = -cy; sn = cx;  end
      2'd2: begin cs = -cx; sn = -cy; end
      default: begin cs = cy; sn = -cx; end
    endcase
    x = longint'(rng) * cs;
    y = longint'(rng) * sn;
    u = apply_row(sh_pu, x, y);
    v = apply_row(sh_pv, x, y);
    w = apply_row(sh_pw, x, y);
    wl = (sh_width > 4096) ? 4096 : sh_width;
    hl = (sh_height > 4096) ? 4096 : sh_height;
    p = '0;
    if (w != 0) begin
      col = u / w;
      row = v / w;
      if (row > 0 && row < hl && col > 0 && col < wl) begin
        p.col = col[11:0];
        p.row = row[11:0];
        p.in_frame = 1'b1;
      end
    end
    return p;
  endfunction

  // register shadow, prediction and comparison
  always @(posedge clk) begin
    pixel_t exp_px, got;
    bit     push, pop;
    if (rst) begin
      sh_start <= '0; sh_step <= '0; sh_width <= 13'd640; sh_height <= 13'd480;
      sh_pu <= '0; sh_pv <= '0; sh_pw <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= 0;
      errors <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          lbpp_pkg::REG_ANGLE_START: sh_start  <= cfg_data[15:0];
          lbpp_pkg::REG_ANGLE_STEP:  sh_step   <= cfg_data[15:0];
          lbpp_pkg::REG_IMG_WIDTH:   sh_width  <= cfg_data[12:0];
          lbpp_pkg::REG_IMG_HEIGHT:  sh_height <= cfg_data[12:0];
          lbpp_pkg::REG_PROJ_U:      sh_pu     <= cfg_data;
          lbpp_pkg::REG_PROJ_V:      sh_pv     <= cfg_data;
          lbpp_pkg::REG_PROJ_W:      sh_pw     <= cfg_data;
          default: ;
        endcase
      end
      push = s_tvalid && s_tready;
      pop  = 1'b0;
      if (push) begin
        exp_mem[wr_ptr] <= project_beam(s_tdata[11:0], s_tdata[27:12]);
        wr_ptr <= wr_ptr + 6'd1;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[11:0], m_tdata[23:12], m_tuser};
        if (count == 0) begin
          if (errors < 10) $display("unexpected result transfer %h", got);
          errors <= errors + 1;
        end else begin
          pop = 1'b1;
          exp_px = exp_mem[rd_ptr];
          rd_ptr <= rd_ptr + 6'd1;
          if (got !== exp_px) begin
            if (errors < 10)
              $display("mismatch: expected col %0d row %0d in %b, got col %0d row %0d in %b",
                       exp_px.col, exp_px.row, exp_px.in_frame,
                       got.col, got.row, got.in_frame);
            errors <= errors + 1;
          end
        end
      end
      count <= count + int'(push) - int'(pop);
    end
  end
endmodule

/* tb/lidar_beam_to_pixel_projection_unit_tb.sv */
// top of the projection unit testbench: clock, reset, stimulus and verdict
// depends on lbpp_pkg, the unit and lidar_beam_to_pixel_projection_unit_checker
`timescale 1ns / 100ps
module lidar_beam_to_pixel_projection_unit_tb;
  localparam int         CW         = lbpp_pkg::CFG_BITS;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [CW-1:0]       cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;
  logic                m_tuser;
  int                  errors, pending;
  int                  send_idle = 0, recv_stall = 0;
  int                  hold_req = 0, hold_cnt = 0;
  bit                  hold_done = 0;
  bit                  narrow = 0;

  always #5 clk = ~clk;

  lidar_beam_to_pixel_projection_unit dut (.*);

  lidar_beam_to_pixel_projection_unit_checker chk (.*);

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0 && !hold_done) begin
      hold_cnt  <= hold_req;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [CW-1:0] pack_row(int c0, int c1, int c2);
    return {c2[17:0], c1[17:0], c0[17:0]};
  endfunction

  task automatic send_beam(logic [11:0] idx, logic [15:0] rng);
    bit ok;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, rng, idx};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CW-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  // a projection that maps short ranges into a 640 x 480 frame
  task automatic load_pinhole(int s0, int s1);
    write_reg(lbpp_pkg::REG_ANGLE_START, CW'(s0));
    write_reg(lbpp_pkg::REG_ANGLE_STEP, CW'(s1));
    write_reg(lbpp_pkg::REG_IMG_WIDTH, CW'(640));
    write_reg(lbpp_pkg::REG_IMG_HEIGHT, CW'(480));
    write_reg(lbpp_pkg::REG_PROJ_U, pack_row(16, 0, 320 * 16));
    write_reg(lbpp_pkg::REG_PROJ_V, pack_row(0, 16, 240 * 16));
    write_reg(lbpp_pkg::REG_PROJ_W, pack_row($urandom_range(3), $urandom_range(3), 16));
  endtask

  task automatic random_beams(int n);
    logic [15:0] rng;
    for (int i = 0; i < n; i++) begin
      if (narrow && $urandom_range(9) != 0) rng = 16'($urandom_range(400));
      else rng = 16'($urandom);
      send_beam(12'($urandom), rng);
    end
  endtask

  initial begin
    #20_000_000;
    $display("lidar_beam_to_pixel_projection_unit test failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: zero divisor everywhere
    send_beam(12'd0, 16'd0);
    send_beam(12'hFFF, 16'hFFFF);
    drain();

    // directed: extremes of index, range and angle wrap, plus an ignored index
    load_pinhole(-32768, 32767);
    write_reg(REG_UNUSED, '1);
    send_beam(12'd0, 16'd0);
    send_beam(12'hFFF, 16'hFFFF);
    send_beam(12'd0, 16'hFFFF);
    send_beam(12'hFFF, 16'd0);
    for (int i = 0; i < 8; i++) send_beam(12'(i * 512), 16'd300);
    send_beam(12'd1, 16'd1);
    send_beam(12'd2, 16'd250);
    drain();
    // zero and oversized image dimensions
    write_reg(lbpp_pkg::REG_IMG_WIDTH, CW'(0));
    send_beam(12'd3, 16'd100);
    drain();
    write_reg(lbpp_pkg::REG_IMG_WIDTH, CW'(13'h1FFF));
    write_reg(lbpp_pkg::REG_IMG_HEIGHT, CW'(13'h1FFF));
    send_beam(12'd5, 16'd100);
    send_beam(12'd9, 16'hFFFF);
    drain();
    // extreme coefficients
    write_reg(lbpp_pkg::REG_PROJ_U, pack_row(131071, -131072, 131071));
    write_reg(lbpp_pkg::REG_PROJ_V, pack_row(-131072, 131071, -131072));
    write_reg(lbpp_pkg::REG_PROJ_W, pack_row(-131072, -131072, 131071));
    send_beam(12'hFFF, 16'hFFFF);
    send_beam(12'h800, 16'hFFFF);
    send_beam(12'd0, 16'd1);
    drain();

    // random phases over idling modes and settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        3: begin send_idle = 6;  recv_stall = 6;  end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) begin
        narrow = 0;
        write_reg(lbpp_pkg::REG_ANGLE_START, CW'($urandom));
        write_reg(lbpp_pkg::REG_ANGLE_STEP, CW'($urandom));
        write_reg(lbpp_pkg::REG_IMG_WIDTH, CW'($urandom_range(8191)));
        write_reg(lbpp_pkg::REG_IMG_HEIGHT, CW'($urandom_range(8191)));
        write_reg(lbpp_pkg::REG_PROJ_U, CW'({$urandom, $urandom}));
        write_reg(lbpp_pkg::REG_PROJ_V, CW'({$urandom, $urandom}));
        write_reg(lbpp_pkg::REG_PROJ_W, CW'({$urandom, $urandom}));
      end else begin
        narrow = 1;
        load_pinhole($urandom, $urandom_range(64));
      end
      if (ph == 0) hold_req = 300;
      random_beams(170);
      drain();
    end

    if (errors == 0)
      $display("lidar_beam_to_pixel_projection_unit test passed");
    else
      $display("lidar_beam_to_pixel_projection_unit test failed");
    $finish;
  end
endmodule
